// File: hdl/assert_macros.svh
// Assertion macros used by the hash map back end.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("check failed");
`define CHK_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("check failed");
`endif

// File: hdl/oahm_pkg.sv
// Types and constants for the open-address hash map.
// No dependencies.
package oahm_pkg;
   localparam logic [31:0] HASH_MULT  = 32'd2654435761;
   localparam int          HASH_SHIFT = 4;
   localparam int          LOAD_DEN   = 10;
   localparam int          LOAD_NUM   = 7;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_MISSING = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_TAKE   = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HASH,
      BK_READ,
      BK_WAIT,
      BK_CHECK,
      BK_SCRUB,
      BK_DONE
   } back_state_type;
endpackage

// File: hdl/oahm_front.sv
// Front end: accepts request words, computes the home slot, two-entry queue.
// Depends on oahm_pkg.
module oahm_front
   import oahm_pkg::*;
#(
   parameter int SLOT_BITS = 8,
   parameter int KEY_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [31:0]          req_key,
   input  logic [31:0]          req_value,
   output logic                 q_valid,
   input  logic                 q_pop,
   output logic                 q_opcode,
   output logic [KEY_BITS-1:0]  q_key,
   output logic [31:0]          q_value,
   output logic [SLOT_BITS-1:0] q_home
);
   logic                 op_ff [2];
   logic [KEY_BITS-1:0]  key_ff [2];
   logic [31:0]          val_ff [2];
   logic [SLOT_BITS-1:0] home_ff [2];
   logic [1:0]           cnt_ff, cnt_in;
   logic                 wr_ff, wr_in, rd_ff, rd_in;
   logic [KEY_BITS-1:0]  key_ext;
   logic [KEY_BITS-1:0]  key_sh;
   logic [63:0]          prod;
   logic                 push;

   always_comb begin
      if (KEY_BITS >= 32) key_ext = KEY_BITS'(req_key);
      else                key_ext = req_key[KEY_BITS-1:0];
      key_sh = key_ext >> HASH_SHIFT;
      prod   = 64'(key_sh[SLOT_BITS-1:0]) * 64'(HASH_MULT);
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_opcode  = op_ff[rd_ff];
   assign q_key     = key_ff[rd_ff];
   assign q_value   = val_ff[rd_ff];
   assign q_home    = home_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = (q_pop && q_valid) ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ff]   <= req_opcode;
         key_ff[wr_ff]  <= key_ext;
         val_ff[wr_ff]  <= req_value;
         home_ff[wr_ff] <= prod[SLOT_BITS-1:0];
      end
   end
endmodule

// File: hdl/oahm_back.sv
// Back end: probes the slot table and produces the response word.
// Depends on oahm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module oahm_back
   import oahm_pkg::*;
#(
   parameter int SLOT_BITS = 8,
   parameter int KEY_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  logic                 q_opcode,
   input  logic [KEY_BITS-1:0]  q_key,
   input  logic [31:0]          q_value,
   input  logic [SLOT_BITS-1:0] q_home,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_found_value
);
   localparam int SLOTS = 1 << SLOT_BITS;
   localparam int LIMIT = (SLOTS * LOAD_NUM + LOAD_DEN - 1) / LOAD_DEN;

   logic [KEY_BITS-1:0]  key_mem [SLOTS];
   logic [31:0]          val_mem [SLOTS];
   logic [1:0]           mark_mem [SLOTS];
   logic [SLOTS-1:0]     touched_ff;

   back_state_type       st_ff, st_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [SLOT_BITS:0]   probes_ff, probes_in;
   logic [SLOT_BITS:0]   live_ff, live_in;
   logic                 op_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [31:0]          val_ff;
   logic [SLOT_BITS-1:0] home_ff;
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [31:0]          rd_val_ff;
   logic [1:0]           rd_mark_ff;
   logic                 rd_touched_ff;
   logic [1:0]           status_ff, status_in;
   logic [31:0]          found_ff, found_in;
   mark_type             cur_mark;
   logic                 do_wr;
   logic                 refuse;

   assign cur_mark = rd_touched_ff ? mark_type'(rd_mark_ff) : MARK_EMPTY;
   assign refuse   = (32'(live_ff) + 32'd1) >= 32'(LIMIT);

   always_comb begin
      st_in     = st_ff;
      slot_in   = slot_ff;
      probes_in = probes_ff;
      live_in   = live_ff;
      status_in = status_ff;
      found_in  = found_ff;
      do_wr     = 1'b0;
      case (st_ff)
         BK_IDLE: if (q_valid) st_in = BK_HASH;
         BK_HASH: begin
            slot_in   = home_ff;
            probes_in = '0;
            found_in  = '0;
            if (op_ff == OP_INSERT && refuse) begin
               status_in = ST_FULL;
               st_in     = BK_DONE;
            end else if (op_ff == OP_TAKE && live_ff == '0) begin
               status_in = ST_MISSING;
               st_in     = BK_DONE;
            end else begin
               st_in = BK_READ;
            end
         end
         BK_READ: st_in = BK_WAIT;
         BK_WAIT: st_in = BK_CHECK;
         BK_CHECK: begin
            if (op_ff == OP_INSERT) begin
               if (cur_mark != MARK_LIVE) begin
                  do_wr     = 1'b1;
                  live_in   = live_ff + 1'b1;
                  status_in = ST_DONE;
                  st_in     = BK_DONE;
               end
            end else begin
               if (cur_mark == MARK_EMPTY) begin
                  status_in = ST_MISSING;
                  st_in     = BK_DONE;
               end else if (cur_mark == MARK_LIVE && rd_key_ff == key_ff) begin
                  do_wr     = 1'b1;
                  found_in  = rd_val_ff;
                  live_in   = live_ff - 1'b1;
                  status_in = ST_DONE;
                  st_in     = BK_DONE;
               end
            end
            if (st_in == BK_CHECK) begin
               probes_in = probes_ff + 1'b1;
               slot_in   = slot_ff + 1'b1;
               if (probes_in == (SLOT_BITS+1)'(SLOTS)) begin
                  status_in = (op_ff == OP_INSERT) ? ST_FULL : ST_MISSING;
                  st_in     = BK_DONE;
               end else begin
                  st_in = BK_READ;
               end
            end
         end
         BK_SCRUB: st_in = BK_DONE;
         BK_DONE: if (!rsp_stall) st_in = BK_IDLE;
         default: st_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = (st_ff == BK_IDLE) && q_valid;
      rsp_valid = (st_ff == BK_DONE);
   end

   assign rsp_status      = status_ff;
   assign rsp_found_value = found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= BK_IDLE;
         live_ff    <= '0;
         touched_ff <= '0;
      end else begin
         st_ff   <= st_in;
         live_ff <= live_in;
         if (do_wr) touched_ff[slot_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      if (q_pop) begin
         op_ff   <= q_opcode;
         key_ff  <= q_key;
         val_ff  <= q_value;
         home_ff <= q_home;
      end
      rd_key_ff     <= key_mem[slot_ff];
      rd_val_ff     <= val_mem[slot_ff];
      rd_mark_ff    <= mark_mem[slot_ff];
      rd_touched_ff <= touched_ff[slot_ff];
      if (do_wr) begin
         key_mem[slot_ff]  <= key_ff;
         val_mem[slot_ff]  <= (op_ff == OP_INSERT) ? val_ff : 32'd0;
         mark_mem[slot_ff] <= (op_ff == OP_INSERT) ? MARK_LIVE : MARK_TOMB;
      end
   end

   `CHK_IMPL(a_live_cap, clock, reset, 1'b1, 32'(live_ff) < 32'(LIMIT))
   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))
   `CHK_IMPL(a_found_zero, clock, reset, rsp_valid && rsp_status != ST_DONE,
      rsp_found_value == 32'd0)
   `CHK_NEXT(a_live_step, clock, reset, st_ff != BK_CHECK, live_ff == $past(live_ff))
endmodule

// File: hdl/open_address_hash_map_top.sv
// Top level of the open-address hash map: front end, queue and prober.
// Depends on oahm_pkg, oahm_front, oahm_back.
//
//  channel | direction | handshake            | words
//  req     | in        | req_valid/req_stall  | opcode, key, value
//  rsp     | out       | rsp_valid/rsp_stall  | status, found_value
//
// Each request passes the pop, hash and response states, plus, per probed slot,
// the address, registered slot memory read and check states; a refused insert
// or a take on an empty map goes from hash straight to the response.
// Reset clears state directly: slot valid bits are flip-flops.
// A stalled response holds the prober; the front queue keeps taking up to
// two requests meanwhile.
module open_address_hash_map_top
   import oahm_pkg::*;
#(
   parameter int SLOT_BITS = 8,
   parameter int KEY_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_value
);
   logic                 q_valid, q_pop, q_opcode;
   logic [KEY_BITS-1:0]  q_key;
   logic [31:0]          q_value;
   logic [SLOT_BITS-1:0] q_home;

   oahm_front #(.SLOT_BITS(SLOT_BITS), .KEY_BITS(KEY_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_opcode, .req_key, .req_value,
      .q_valid, .q_pop, .q_opcode, .q_key, .q_value, .q_home
   );

   oahm_back #(.SLOT_BITS(SLOT_BITS), .KEY_BITS(KEY_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_opcode, .q_key, .q_value, .q_home,
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_found_value
   );
endmodule

// File: tb/open_address_hash_map_top_test.sv
// Self-checking testbench for open_address_hash_map_top: random insert/take
// traffic against a behavioral linear-probing table, with random idling.
// Depends on oahm_pkg and the hash map RTL.
`timescale 1ns / 100ps

module open_address_hash_map_top_test;
   import oahm_pkg::*;

   localparam int NSLOTS = 256;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      opcode_type  op;
      logic [31:0] key;
      logic [31:0] value;
   } req_word_t;

   typedef struct packed {
      status_type  status;
      logic [31:0] found;
   } rsp_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   logic [31:0] req_key = '0;
   logic [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [31:0] rsp_found_value;

   open_address_hash_map_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_key(req_key), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_found_value(rsp_found_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow table
   logic [31:0] tbl_key [NSLOTS];
   logic [31:0] tbl_value [NSLOTS];
   mark_type    tbl_mark [NSLOTS];
   int          tbl_live;

   req_word_t pending_q[$];
   rsp_word_t expected_q[$];
   logic [31:0] live_keys[$];
   int errors = 0;
   int accepted = 0;
   int received = 0;
   int n_pushed = 0;
   int n_full = 0, n_done = 0, n_miss = 0;
   int idle_cycles = 0;

   function automatic int home_of(logic [31:0] key);
      logic [63:0] mixed;
      mixed = {36'd0, key[31:4]} * {32'd0, HASH_MULT};
      return int'(mixed[7:0]);
   endfunction

   function automatic rsp_word_t apply_word(req_word_t w);
      rsp_word_t r;
      int s;
      r.status = ST_DONE;
      r.found = '0;
      s = home_of(w.key);
      if (w.op == OP_INSERT) begin
         if ((tbl_live + 1) * LOAD_DEN >= NSLOTS * LOAD_NUM) begin
            r.status = ST_FULL;
            return r;
         end
         for (int n = 0; n < NSLOTS; n++) begin
            if (tbl_mark[s] != MARK_LIVE) begin
               tbl_key[s] = w.key;
               tbl_value[s] = w.value;
               tbl_mark[s] = MARK_LIVE;
               tbl_live++;
               return r;
            end
            s = (s + 1) % NSLOTS;
         end
         r.status = ST_FULL;
         return r;
      end
      r.status = ST_MISSING;
      if (tbl_live == 0) return r;
      for (int n = 0; n < NSLOTS; n++) begin
         if (tbl_mark[s] == MARK_EMPTY) return r;
         if (tbl_mark[s] == MARK_LIVE && tbl_key[s] == w.key) begin
            r.status = ST_DONE;
            r.found = tbl_value[s];
            tbl_mark[s] = MARK_TOMB;
            tbl_live--;
            return r;
         end
         s = (s + 1) % NSLOTS;
      end
      return r;
   endfunction

   function automatic req_word_t mk(opcode_type op, logic [31:0] k, logic [31:0] v);
      req_word_t w;
      w.op = op;
      w.key = k;
      w.value = v;
      return w;
   endfunction

   // keys sharing a home slot: reuse a small pool of bases to force
   // collisions and duplicates
   function automatic logic [31:0] pick_key();
      int sel;
      logic [31:0] k;
      sel = $urandom_range(0, 9);
      if (sel < 4 && live_keys.size() > 0)
         return live_keys[$urandom_range(0, live_keys.size() - 1)];
      if (sel < 7) begin
         k = {22'd0, 6'($urandom_range(0, 63)), 4'h0};
         if (sel == 5) k[3:0] = 4'($urandom_range(0, 15));
         return k;
      end
      return $urandom;
   endfunction

   // driver
   int req_wait = 0;
   int req_taken = 0;
   always @(negedge clock) begin
      bit busy;
      busy = req_valid;
      if (busy && accepted != req_taken) begin
         req_taken = accepted;
         busy = 1'b0;
      end
      if (!busy && !reset) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (pending_q.size() > 0) begin
            {req_opcode, req_key, req_value} <= pending_q.pop_front();
            busy = 1'b1;
            req_wait = $urandom_range(0, 15);
         end
      end
      req_valid <= busy;
   end

   // sample at rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_q.push_back(apply_word(mk(opcode_type'(req_opcode), req_key, req_value)));
         accepted++;
      end
   end

   // result side idling: a fresh wait is drawn after every accepted result
   int rsp_wait = 0;
   int rsp_taken = 0;
   always @(negedge clock) begin
      if (received != rsp_taken) begin
         rsp_taken = received;
         rsp_wait = $urandom_range(0, 15);
      end
      if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_word_t exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         received++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result status=%0d value=%h",
               rsp_status, rsp_found_value);
         end else begin
            exp_w = expected_q.pop_front();
            case (exp_w.status)
               ST_FULL: n_full++;
               ST_MISSING: n_miss++;
               default: n_done++;
            endcase
            if (rsp_status !== exp_w.status || rsp_found_value !== exp_w.found) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected status=%0d value=%h, got status=%0d value=%h",
                     exp_w.status, exp_w.found, rsp_status, rsp_found_value);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress");
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic push(req_word_t w);
      pending_q.push_back(w);
      n_pushed++;
      if (w.op == OP_INSERT) live_keys.push_back(w.key);
      if (live_keys.size() > 64) void'(live_keys.pop_front());
   endtask

   // sender pauses until every expected result has come
   task automatic drain();
      wait (received == n_pushed);
   endtask

   initial begin
      for (int i = 0; i < NSLOTS; i++) begin
         tbl_mark[i] = MARK_EMPTY;
         tbl_key[i] = '0;
         tbl_value[i] = '0;
      end
      tbl_live = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // directed
      push(mk(OP_TAKE, 32'h0, 32'hFFFF_FFFF));
      push(mk(OP_INSERT, 32'h0, 32'h0));
      push(mk(OP_INSERT, 32'h1, 32'hFFFF_FFFF));
      push(mk(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A));
      push(mk(OP_INSERT, 32'h1, 32'h1234_5678));
      push(mk(OP_INSERT, 32'h2, 32'h5555_AAAA));
      push(mk(OP_TAKE, 32'h1, 32'h0));
      push(mk(OP_TAKE, 32'h1, 32'hFFFF_FFFF));
      push(mk(OP_TAKE, 32'h1, 32'h0));
      push(mk(OP_TAKE, 32'h2, 32'h0));
      push(mk(OP_TAKE, 32'h0, 32'h0));
      push(mk(OP_TAKE, 32'hFFFF_FFFF, 32'h0));
      push(mk(OP_TAKE, 32'h8000_0000, 32'h0));
      drain();
      // random: phases of filling to full, then draining
      for (int phase = 0; phase < 6; phase++) begin
         for (int i = 0; i < 210; i++) begin
            int fill_bias;
            fill_bias = (phase % 2 == 0) ? 7 : 3;
            if ($urandom_range(0, 9) < fill_bias)
               push(mk(OP_INSERT, pick_key(), $urandom));
            else
               push(mk(OP_TAKE, pick_key(), $urandom));
         end
         if (phase == 2) drain();
      end
      drain();
      repeat (50) @(posedge clock);
      $display("%0d requests, %0d results: %0d done, %0d misses, %0d full refusals",
         accepted, received, n_done, n_miss, n_full);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
